>>> rtl/rgmm_pkg.sv
// ----------------------------------------------------------------------------
// rgmm_pkg
// Shared types and constants of the ramped gain matrix mixer.
// ----------------------------------------------------------------------------
package rgmm_pkg;

	localparam int TRACKS_DEF = 16;
	localparam int SLOTS_DEF  = 12;
	localparam int FRAME_DEF  = 2048;

	localparam logic [3:0] SLOTS_IN_USE_RST = 4'd12;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		CMD_STAGE = 2'd0,
		CMD_RAMP  = 2'd1,
		CMD_MIX   = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_STG_RD,
		ST_STG_WR,
		ST_RMP_LEN,
		ST_RMP_RD,
		ST_RMP_CALC,
		ST_RMP_DIV,
		ST_MIX_RRD,
		ST_MIX_RUP,
		ST_MIX_GRD,
		ST_MIX_GUP,
		ST_MIX_MUL,
		ST_MIX_ACC,
		ST_RD_RD,
		ST_RD_OUT
	} state_t;

	// one gain memory entry: Q11.20 step, Q3.20 target and current
	typedef struct packed {
		logic signed [31:0] step;
		logic signed [23:0] target;
		logic signed [23:0] current;
	} gain_ent_t;

	function automatic logic signed [23:0] sat24(input logic signed [40:0] v);
		logic signed [23:0] r;
		if (v > 41'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -41'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/rgmm_ram.sv
// ----------------------------------------------------------------------------
// rgmm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rgmm_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/rgmm_div.sv
// ----------------------------------------------------------------------------
// rgmm_div
// Radix-2 restoring divider: signed 25-bit dividend by unsigned 16-bit
// divisor, quotient truncated toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module rgmm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [24:0] dividend,
	input  logic [15:0]        divisor,
	output logic               busy,
	output logic               done,
	output logic signed [31:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic [16:0] rem_q;
	logic [24:0] quo_q;
	logic [15:0] div_q;
	logic [16:0] trial;
	logic        fits;

	assign trial = {rem_q[15:0], quo_q[24]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd24;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[24];
			quo_q <= dividend[24] ? 25'(-dividend) : 25'(dividend);
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, div_q}) : trial;
			quo_q <= {quo_q[23:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? -{7'd0, quo_q} : {7'd0, quo_q};

endmodule

>>> rtl/ramped_gain_matrix_mixer.sv
// ----------------------------------------------------------------------------
// ramped_gain_matrix_mixer
// Per-track gain matrix with linear gain ramps, mixed into a frame buffer.
// ----------------------------------------------------------------------------
// One command is worked at a time. After reset a clearing pass zeroes the
// gain, ramp and accumulator memories; no transfer is taken in then. In a
// mix each slot costs one read-modify-write of the gain and accumulator RAMs
// (registered read data) through one shared multiplier. Staging a target
// reads and rewrites one gain entry; a mix reads and counts down the track's
// ramp, then per slot updates the current gain, multiplies and accumulates;
// starting a ramp stores its length, then per slot either jumps (zero
// length) or runs the bit-serial divider for the step; a readout reads and
// clears each accumulator entry, waiting out any output stall. A result waits
// in an output register while the next command is accepted.
module ramped_gain_matrix_mixer
	import rgmm_pkg::*;
#(
	parameter int TRACKS        = TRACKS_DEF,
	parameter int SLOTS         = SLOTS_DEF,
	parameter int FRAME_SAMPLES = FRAME_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             slots_in_use_we,
	input  logic [3:0]                       slots_in_use_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// track[3:0], slot[7:4], gain_value[31:8], ramp_length[47:32],
	// position[58:48], sample_value[82:59], zero fill above
	input  logic [rgmm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// cmd[1:0]
	input  logic [1:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// mixed_value[23:0]
	output logic [rgmm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// out_slot[3:0]
	output logic [3:0]                       m_axis_tuser,
	output logic                             m_axis_tlast
);

	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TW  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int FW  = $clog2(FRAME_SAMPLES);
	localparam int PW  = (FW > 11) ? FW : 11;
	localparam int TXW = (TW > 4) ? TW : 4;
	localparam int GAW = TW + SW;
	localparam int AAW = FW + SW;
	localparam int GAIN_DEPTH = 2 ** GAW;
	localparam int ACC_DEPTH  = 2 ** AAW;
	localparam int RAMP_DEPTH = 2 ** TW;
	localparam int CLR_DEPTH  = (ACC_DEPTH > GAIN_DEPTH) ? ACC_DEPTH : GAIN_DEPTH;
	localparam int CW  = $clog2(CLR_DEPTH);

	state_t state_q, state_d;

	logic [3:0]         slots_in_use_q;
	logic [4:0]         n_act;
	logic [CW-1:0]      clr_cnt_q;
	logic [SW-1:0]      s_q;
	logic               slot_last;
	logic               slot_done;
	logic               slot_act;

	logic [TXW-1:0]     trk_q;
	logic signed [23:0] gain_q;
	logic [15:0]        len_q;
	logic [PW-1:0]      pos_q;
	logic signed [23:0] smp_q;
	logic               pos_ok_q;
	logic               dec_q;
	logic               rz_q;
	logic signed [23:0] cur_q;
	logic signed [47:0] prod_q;

	logic               in_fire;
	logic               in_trk_ok;
	logic               in_slot_ok;
	cmd_t               in_cmd;

	logic               out_valid_q;
	logic signed [23:0] out_data_q;
	logic [3:0]         out_slot_q;
	logic               out_last_q;
	logic               out_free;
	logic               out_load;

	logic               g_we, g_re;
	logic [GAW-1:0]     g_waddr, g_raddr, g_addr;
	gain_ent_t          g_wdata, g_rdata;
	logic               r_we, r_re;
	logic [TW-1:0]      r_waddr, r_addr;
	logic [15:0]        r_wdata, r_rdata, r_dec;
	logic               a_we, a_re;
	logic [AAW-1:0]     a_waddr, a_addr;
	logic [39:0]        a_wdata, a_rdata;

	logic               div_start, div_busy, div_done;
	logic signed [24:0] div_dvd;
	logic signed [31:0] div_quo;

	logic signed [32:0] cur_sum;
	logic signed [23:0] cur_new;
	logic signed [27:0] prod_sh;
	logic signed [40:0] acc_sum;
	logic [39:0]        acc_new;

	assign in_cmd     = cmd_t'(s_axis_tuser);
	assign in_fire    = s_axis_tvalid && s_axis_tready;
	assign in_trk_ok  = 32'(s_axis_tdata[3:0]) < TRACKS;
	assign in_slot_ok = 32'(s_axis_tdata[7:4]) < SLOTS;

	assign n_act     = (32'(slots_in_use_q) < SLOTS) ? 5'(slots_in_use_q) : 5'(SLOTS);
	assign slot_last = s_q == SW'(SLOTS - 1);
	assign slot_act  = 5'(s_q) < n_act;
	assign out_free  = !out_valid_q || m_axis_tready;

	assign g_addr = {trk_q[TW-1:0], s_q};
	assign r_addr = trk_q[TW-1:0];
	assign a_addr = {pos_q[FW-1:0], s_q};
	assign r_dec  = r_rdata - 16'd1;

	// ramp step of the current gain, saturated, or the target on the ramp's last step
	assign cur_sum = {{9{g_rdata.current[23]}}, g_rdata.current} + {g_rdata.step[31], g_rdata.step};
	assign cur_new = !dec_q ? g_rdata.current :
	                 rz_q   ? g_rdata.target  : sat24(41'(cur_sum));

	assign prod_sh = prod_q[47:20];
	assign acc_sum = {a_rdata[39], a_rdata} + {{13{prod_sh[27]}}, prod_sh};
	assign acc_new = (acc_sum[40] != acc_sum[39]) ?
	                 (acc_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}}) : acc_sum[39:0];

	assign div_dvd = {g_rdata.target[23], g_rdata.target} - {g_rdata.current[23], g_rdata.current};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (32'(clr_cnt_q) == CLR_DEPTH - 1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_fire) begin
					unique case (in_cmd)
						CMD_STAGE: state_d = (in_trk_ok && in_slot_ok) ? ST_STG_RD : ST_IDLE;
						CMD_RAMP:  state_d = in_trk_ok ? ST_RMP_LEN : ST_IDLE;
						CMD_MIX:   state_d = in_trk_ok ? ST_MIX_RRD : ST_IDLE;
						CMD_READ:  state_d = ST_RD_RD;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_STG_RD:   state_d = ST_STG_WR;
			ST_STG_WR:   state_d = ST_IDLE;
			ST_RMP_LEN:  state_d = ST_RMP_RD;
			ST_RMP_RD:   state_d = ST_RMP_CALC;
			ST_RMP_CALC: begin
				if (len_q != 16'd0) state_d = ST_RMP_DIV;
				else state_d = slot_last ? ST_IDLE : ST_RMP_RD;
			end
			ST_RMP_DIV: begin
				if (div_done) state_d = slot_last ? ST_IDLE : ST_RMP_RD;
			end
			ST_MIX_RRD:  state_d = ST_MIX_RUP;
			ST_MIX_RUP:  state_d = ST_MIX_GRD;
			ST_MIX_GRD:  state_d = ST_MIX_GUP;
			ST_MIX_GUP:  state_d = ST_MIX_MUL;
			ST_MIX_MUL:  state_d = ST_MIX_ACC;
			ST_MIX_ACC:  state_d = slot_last ? ST_IDLE : ST_MIX_GRD;
			ST_RD_RD:    state_d = ST_RD_OUT;
			ST_RD_OUT: begin
				if (!slot_act || out_free) state_d = slot_last ? ST_IDLE : ST_RD_RD;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory ports and strobes
	always_comb begin
		s_axis_tready = 1'b0;
		g_we = 1'b0; g_re = 1'b0; g_waddr = g_addr; g_raddr = g_addr; g_wdata = g_rdata;
		r_we = 1'b0; r_re = 1'b0; r_waddr = r_addr; r_wdata = r_dec;
		a_we = 1'b0; a_re = 1'b0; a_waddr = a_addr; a_wdata = acc_new;
		div_start = 1'b0;
		slot_done = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				g_we    = 32'(clr_cnt_q) < GAIN_DEPTH;
				g_waddr = clr_cnt_q[GAW-1:0];
				g_wdata = '0;
				r_we    = 32'(clr_cnt_q) < RAMP_DEPTH;
				r_waddr = clr_cnt_q[TW-1:0];
				r_wdata = '0;
				a_we    = 32'(clr_cnt_q) < ACC_DEPTH;
				a_waddr = clr_cnt_q[AAW-1:0];
				a_wdata = '0;
			end
			ST_IDLE: s_axis_tready = 1'b1;
			ST_STG_RD: g_re = 1'b1;
			ST_STG_WR: begin
				g_we = 1'b1;
				g_wdata.target = gain_q;
			end
			ST_RMP_LEN: begin
				r_we    = 1'b1;
				r_wdata = len_q;
			end
			ST_RMP_RD: g_re = 1'b1;
			ST_RMP_CALC: begin
				if (len_q == 16'd0) begin
					g_we = 1'b1;
					g_wdata.step    = '0;
					g_wdata.current = g_rdata.target;
					slot_done = 1'b1;
				end else begin
					div_start = 1'b1;
				end
			end
			ST_RMP_DIV: begin
				if (div_done) begin
					g_we = 1'b1;
					g_wdata.step = div_quo;
					slot_done = 1'b1;
				end
			end
			ST_MIX_RRD: r_re = 1'b1;
			ST_MIX_RUP: r_we = r_rdata != 16'd0;
			ST_MIX_GRD: begin
				g_re = 1'b1;
				a_re = 1'b1;
			end
			ST_MIX_GUP: begin
				g_we = dec_q;
				g_wdata.current = cur_new;
			end
			ST_MIX_MUL: ;
			ST_MIX_ACC: begin
				a_we = pos_ok_q && slot_act;
				slot_done = 1'b1;
			end
			ST_RD_RD: a_re = 1'b1;
			ST_RD_OUT: begin
				if (!slot_act || out_free) begin
					a_we     = pos_ok_q;
					a_wdata  = '0;
					out_load = slot_act;
					slot_done = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLR;
			clr_cnt_q      <= '0;
			slots_in_use_q <= SLOTS_IN_USE_RST;
			s_q            <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) clr_cnt_q <= clr_cnt_q + CW'(1);
			if (slots_in_use_we) slots_in_use_q <= slots_in_use_wdata;
			// staging addresses its own slot, every other command walks from slot 0
			if (in_fire) s_q <= (in_cmd == CMD_STAGE) ? SW'(s_axis_tdata[7:4]) : '0;
			else if (slot_done) s_q <= slot_last ? '0 : s_q + SW'(1);
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			trk_q    <= TXW'(s_axis_tdata[3:0]);
			gain_q   <= s_axis_tdata[31:8];
			len_q    <= s_axis_tdata[47:32];
			pos_q    <= PW'(s_axis_tdata[58:48]);
			pos_ok_q <= 32'(s_axis_tdata[58:48]) < FRAME_SAMPLES;
			smp_q    <= s_axis_tdata[82:59];
		end
		if (state_q == ST_MIX_RUP) begin
			dec_q <= r_rdata != 16'd0;
			rz_q  <= r_dec == 16'd0;
		end
		if (state_q == ST_MIX_GUP) cur_q <= cur_new;
		if (state_q == ST_MIX_MUL) prod_q <= 48'(cur_q) * 48'(smp_q);
		if (out_load) begin
			out_data_q <= pos_ok_q ? sat24({a_rdata[39], a_rdata}) : 24'sd0;
			out_slot_q <= 4'(s_q);
			out_last_q <= 5'(s_q) + 5'd1 == n_act;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_slot_q;
	assign m_axis_tlast  = out_last_q;

	rgmm_ram #(.W($bits(gain_ent_t)), .DEPTH(GAIN_DEPTH)) u_gain_ram (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.re(g_re), .raddr(g_raddr), .rdata(g_rdata)
	);

	rgmm_ram #(.W(16), .DEPTH(RAMP_DEPTH)) u_ramp_ram (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.re(r_re), .raddr(r_addr), .rdata(r_rdata)
	);

	rgmm_ram #(.W(40), .DEPTH(ACC_DEPTH)) u_acc_ram (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.re(a_re), .raddr(a_addr), .rdata(a_rdata)
	);

	rgmm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(len_q), .busy(div_busy), .done(div_done), .quotient(div_quo)
	);

	// the divider runs only while the sequencer waits on it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_RMP_DIV)
		else $error("divider busy outside ramp divide");

	// tlast marks the highest slot in use
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && 5'(s_q) + 5'd1 == n_act) |=> m_axis_tlast)
		else $error("tlast not on final slot");

	// no transfer taken during the clearing pass
	a_clr_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> !s_axis_tready && !a_re && !g_re)
		else $error("access during clearing pass");

	// a result is loaded only when the output register is free
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten");

endmodule

>>> test/tb_ramped_gain_matrix_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ramped_gain_matrix_mixer
// Self-checking bench for the ramped gain matrix mixer. A behavioral copy of
// the gain, ramp and frame accumulator state predicts every readout; each
// output transfer is checked in order against it. Directed commands cover
// field extremes, jumps, long and short ramps, unused slots and saturation;
// random gain/ramp/mix/read sequences follow, with random gaps on both sides
// and one long output stall that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_ramped_gain_matrix_mixer;
	import rgmm_pkg::*;

	localparam int NTRK    = 16;
	localparam int NSLT    = 12;
	localparam int NPOS    = 2048;
	localparam int SETTLE  = 400;
	localparam longint ACC_HI = 64'sd549755813887;
	localparam longint ACC_LO = -64'sd549755813888;

	typedef struct {
		logic [3:0]  slot;
		logic [23:0] value;
		logic        last;
	} slot_mix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        slots_in_use_we = 1'b0;
	logic [3:0]  slots_in_use_wdata = 4'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = 2'd0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// predicted block state
	int        gain_now[NTRK][NSLT];
	int        gain_goal[NTRK][NSLT];
	int        gain_inc[NTRK][NSLT];
	int        ramp_left[NTRK];
	longint    frame_acc[NPOS][NSLT];
	int        layout_slots = 12;
	slot_mix_t readout_q[$];

	int  mismatches = 0;
	bit  sender_busy_only = 0;
	bit  recv_no_gaps = 0;
	bit  long_hold_req = 0;
	int  hold_cnt = 0;

	ramped_gain_matrix_mixer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.slots_in_use_we(slots_in_use_we),
		.slots_in_use_wdata(slots_in_use_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int clamp24(input longint v);
		if (v > 64'sd8388607) return 8388607;
		if (v < -64'sd8388608) return -8388608;
		return int'(v);
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// advance the predicted state by one command, queue any readout
	task automatic apply_cmd(input cmd_t c, input logic [3:0] trk, input logic [3:0] slt,
			input logic [23:0] g, input logic [15:0] len, input logic [10:0] pos,
			input logic [23:0] smp);
		int     n;
		int     gv;
		int     sv;
		longint a;
		slot_mix_t e;
		n  = (layout_slots > NSLT) ? NSLT : layout_slots;
		gv = int'($signed(g));
		sv = int'($signed(smp));
		case (c)
			CMD_READ: begin
				for (int s = 0; s < n; s++) begin
					e.slot  = s[3:0];
					e.value = 24'(clamp24(frame_acc[pos][s]));
					e.last  = (s == n - 1);
					readout_q.push_back(e);
				end
				for (int s = 0; s < NSLT; s++) frame_acc[pos][s] = 0;
			end
			CMD_STAGE: begin
				if (slt < NSLT) gain_goal[trk][slt] = gv;
			end
			CMD_RAMP: begin
				ramp_left[trk] = int'(len);
				for (int s = 0; s < NSLT; s++) begin
					if (len != 0) begin
						gain_inc[trk][s] = int'((longint'(gain_goal[trk][s]) -
							longint'(gain_now[trk][s])) / longint'(len));
					end else begin
						gain_inc[trk][s] = 0;
						gain_now[trk][s] = gain_goal[trk][s];
					end
				end
			end
			default: begin
				if (ramp_left[trk] > 0) begin
					ramp_left[trk]--;
					for (int s = 0; s < NSLT; s++) begin
						if (ramp_left[trk] == 0) gain_now[trk][s] = gain_goal[trk][s];
						else gain_now[trk][s] = clamp24(longint'(gain_now[trk][s]) +
							longint'(gain_inc[trk][s]));
					end
				end
				for (int s = 0; s < n; s++) begin
					// arithmetic shift floors toward minus infinity
					a = frame_acc[pos][s] +
						((longint'(gain_now[trk][s]) * longint'(sv)) >>> 20);
					if (a > ACC_HI) a = ACC_HI;
					if (a < ACC_LO) a = ACC_LO;
					frame_acc[pos][s] = a;
				end
			end
		endcase
	endtask

	// call right after a rising edge; returns right after the accepting edge
	task automatic send_item(input cmd_t c, input logic [3:0] trk, input logic [3:0] slt,
			input logic [23:0] g, input logic [15:0] len, input logic [10:0] pos,
			input logic [23:0] smp);
		int gap;
		gap = sender_busy_only ? 0 : gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= c;
		s_axis_tdata  <= {5'd0, smp, pos, len, g, slt, trk};
		do @(posedge clk); while (!s_axis_tready);
		apply_cmd(c, trk, slt, g, len, pos, smp);
	endtask

	// drop valid, let every readout land and the last command finish
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (readout_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_layout(input logic [3:0] v);
		drain();
		slots_in_use_we    <= 1'b1;
		slots_in_use_wdata <= v;
		@(posedge clk);
		slots_in_use_we <= 1'b0;
		layout_slots = int'(v);
		@(posedge clk);
	endtask

	task automatic read_pos(input logic [10:0] pos);
		send_item(CMD_READ, 4'($urandom), 4'($urandom), 24'($urandom), 16'($urandom), pos,
			24'($urandom));
	endtask

	task automatic test_directed();
		read_pos(11'd0);
		send_item(CMD_STAGE, 4'd0, 4'd0, 24'h7FFFFF, 16'd0, 11'd0, 24'd0);
		send_item(CMD_STAGE, 4'd0, 4'd11, 24'h800000, 16'd0, 11'd0, 24'd0);
		send_item(CMD_STAGE, 4'd0, 4'd15, 24'h123456, 16'd0, 11'd0, 24'd0); // dropped
		send_item(CMD_STAGE, 4'd0, 4'd5, 24'h100000, 16'd0, 11'd0, 24'd0);
		send_item(CMD_RAMP, 4'd0, 4'd0, 24'd0, 16'd0, 11'd0, 24'd0);          // jump
		send_item(CMD_MIX, 4'd0, 4'd0, 24'd0, 16'd0, 11'd2047, 24'h7FFFFF);
		send_item(CMD_MIX, 4'd0, 4'd0, 24'd0, 16'd0, 11'd2047, 24'h7FFFFF);   // saturates
		send_item(CMD_MIX, 4'd0, 4'd0, 24'd0, 16'd0, 11'd1, 24'h800000);
		send_item(CMD_MIX, 4'd0, 4'd0, 24'd0, 16'd0, 11'd1, 24'hFFFFFF);      // floor of -1
		read_pos(11'd2047);
		read_pos(11'd1);
		read_pos(11'd2047);                                                 // cleared
		send_item(CMD_STAGE, 4'd15, 4'd3, 24'h0C0000, 16'd0, 11'd0, 24'd0);
		send_item(CMD_RAMP, 4'd15, 4'd0, 24'd0, 16'd1, 11'd0, 24'd0);
		send_item(CMD_MIX, 4'd15, 4'd0, 24'd0, 16'd0, 11'd3, 24'h400000);
		send_item(CMD_STAGE, 4'd15, 4'd3, 24'hF40000, 16'd0, 11'd0, 24'd0);
		send_item(CMD_RAMP, 4'd15, 4'd0, 24'd0, 16'd65535, 11'd0, 24'd0);
		send_item(CMD_MIX, 4'd15, 4'd0, 24'd0, 16'd0, 11'd3, 24'h400000);
		send_item(CMD_MIX, 4'd15, 4'd0, 24'd0, 16'd0, 11'd3, 24'h3FFFFF);
		send_item(CMD_RAMP, 4'd15, 4'd0, 24'd0, 16'd3, 11'd0, 24'd0);
		send_item(CMD_MIX, 4'd15, 4'd0, 24'd0, 16'd0, 11'd3, 24'h000001);
		read_pos(11'd3);
	endtask

	task automatic test_layouts();
		set_layout(4'd0);
		send_item(CMD_MIX, 4'd0, 4'd0, 24'd0, 16'd0, 11'd4, 24'h7FFFFF);
		read_pos(11'd4);                                                    // no results
		set_layout(4'd15);
		read_pos(11'd4);
		set_layout(4'd1);
		send_item(CMD_MIX, 4'd0, 4'd0, 24'd0, 16'd0, 11'd5, 24'h7FFFFF);
		read_pos(11'd5);
		set_layout(4'd12);
	endtask

	// one well-formed scene: stage gains, start a ramp, mix, then usually read back
	task automatic random_scene(inout int items);
		logic [3:0]  trk;
		logic [15:0] len;
		int          r;
		trk = 4'($urandom);
		repeat ($urandom_range(1, 4)) begin
			send_item(CMD_STAGE, trk, 4'($urandom_range(0, 15)), 24'($urandom),
				16'($urandom), 11'($urandom), 24'($urandom));
			items++;
		end
		r = $urandom_range(0, 9);
		len = (r < 3) ? 16'd0 : (r < 8) ? 16'($urandom_range(1, 6)) : 16'($urandom);
		send_item(CMD_RAMP, trk, 4'($urandom), 24'($urandom), len, 11'($urandom),
			24'($urandom));
		items++;
		repeat ($urandom_range(1, 5)) begin
			send_item(CMD_MIX, trk, 4'($urandom), 24'($urandom), 16'($urandom),
				11'($urandom_range(0, 7)), 24'($urandom));
			items++;
		end
		if ($urandom_range(0, 2) != 0) begin
			read_pos(11'($urandom_range(0, 7)));
			items++;
		end
	endtask

	task automatic test_random(input int target);
		int items;
		items = 0;
		while (items < target) begin
			if ($urandom_range(0, 9) < 8) begin
				random_scene(items);
			end else begin
				send_item(cmd_t'($urandom_range(0, 3)), 4'($urandom), 4'($urandom),
					24'($urandom), 16'($urandom), 11'($urandom), 24'($urandom));
				items++;
			end
		end
		for (int p = 0; p < 8; p++) read_pos(p[10:0]);
	endtask

	task automatic test_backpressure();
		drain();
		long_hold_req    = 1;
		sender_busy_only = 1;
		recv_no_gaps     = 1;
		@(posedge clk);
		send_item(CMD_MIX, 4'd7, 4'd0, 24'd0, 16'd0, 11'd9, 24'h345678);
		for (int i = 0; i < 6; i++) read_pos(11'd9 - i[10:0]);
		sender_busy_only = 0;
		recv_no_gaps     = 0;
	endtask

	// receiver: random stalls, plus one long hold on request
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 0;
			hold_cnt      = 300;
			m_axis_tready <= 1'b0;
		end else if (!recv_no_gaps && $urandom_range(0, 99) < 20) begin
			hold_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
				: $urandom_range(0, 2);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// result check against the oldest predicted readout
	always @(posedge clk) begin
		slot_mix_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (readout_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: slot %0d value %h last %b",
						m_axis_tuser, m_axis_tdata, m_axis_tlast);
			end else begin
				e = readout_q.pop_front();
				if (m_axis_tuser !== e.slot || m_axis_tdata !== e.value ||
						m_axis_tlast !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp slot %0d value %h last %b, got %0d %h %b",
							e.slot, e.value, e.last, m_axis_tuser, m_axis_tdata,
							m_axis_tlast);
				end
			end
		end
	end

	initial begin
		for (int t = 0; t < NTRK; t++) begin
			ramp_left[t] = 0;
			for (int s = 0; s < NSLT; s++) begin
				gain_now[t][s]  = 0;
				gain_goal[t][s] = 0;
				gain_inc[t][s]  = 0;
			end
		end
		for (int p = 0; p < NPOS; p++)
			for (int s = 0; s < NSLT; s++) frame_acc[p][s] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_layouts();
		test_random(65);
		set_layout(4'($urandom_range(1, 11)));
		test_random(45);
		test_backpressure();
		drain();
		if (mismatches == 0 && readout_q.size() == 0) begin
			$display("tb_ramped_gain_matrix_mixer: done, clean");
		end else begin
			if (readout_q.size() != 0)
				$display("%0d expected transfers never arrived", readout_q.size());
			$display("tb_ramped_gain_matrix_mixer: done, errors");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("timeout");
		$display("tb_ramped_gain_matrix_mixer: done, errors");
		$finish;
	end

endmodule

>>> sim.f
rtl/rgmm_pkg.sv
rtl/rgmm_ram.sv
rtl/rgmm_div.sv
rtl/ramped_gain_matrix_mixer.sv
test/tb_ramped_gain_matrix_mixer.sv
